// File: hdl/sscd_pkg.sv
// shared types, constants and decode functions for the seven-segment clock
`timescale 1ns / 1ps

package sscd_pkg;

  localparam int NUM_DIGITS = 5;
  localparam int POS_W = 3;

  localparam logic [15:0] SLOTS_PER_SECOND_RESET = 16'd1155;

  localparam logic [4:0] HOURS_RESET = 5'd12;
  localparam logic [4:0] HOURS_LAST = 5'd23;
  localparam logic [4:0] HOURS_NOON = 5'd12;
  localparam logic [5:0] MINUTES_LAST = 6'd59;
  localparam logic [5:0] SECONDS_LAST = 6'd59;

  // display positions, left to right
  localparam logic [POS_W-1:0] POS_HOUR_TENS = 3'd0;
  localparam logic [POS_W-1:0] POS_HOUR_UNITS = 3'd1;
  localparam logic [POS_W-1:0] POS_MIN_TENS = 3'd2;
  localparam logic [POS_W-1:0] POS_MIN_UNITS = 3'd3;
  localparam logic [POS_W-1:0] POS_INDICATOR = 3'd4;

  localparam logic [6:0] SEG_P = 7'h73;
  localparam logic [6:0] SEG_A = 7'h77;
  localparam logic [6:0] SEG_UNDERSCORE = 7'h08;
  localparam logic [6:0] SEG_BLANK = 7'h00;

  typedef struct packed {
    logic set_hour;
    logic set_minute;
  } buttons_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
  } clock_value_t;

  function automatic logic [6:0] seg_digit(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h67;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // tens digit of a value below 60
  function automatic logic [3:0] dec_tens(input logic [5:0] v);
    logic [3:0] t;
    priority if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] dec_units(input logic [5:0] v);
    logic [5:0] diff;
    diff = v - 6'({2'b00, dec_tens(v)} * 6'd10);
    return diff[3:0];
  endfunction

endpackage

// File: hdl/sscd_timekeeper.sv
// slot counter, seconds, minutes and hours with button setting
`timescale 1ns / 1ps

module sscd_timekeeper (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  sscd_pkg::buttons_t    buttons,
  input  logic [15:0]           slots_per_second,
  output sscd_pkg::clock_value_t now
);

  logic [15:0] slot_r, slot_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;

  logic [16:0] slot_inc;
  logic [16:0] limit;
  logic        tick;
  logic [4:0]  hour_btn;
  logic [5:0]  min_btn;

  assign slot_inc = {1'b0, slot_r} + 17'd1;
  assign limit = (slots_per_second == 16'd0) ? 17'd1 : {1'b0, slots_per_second};
  assign tick = (slot_inc >= limit);

  always_comb begin
    // button step first, no carry
    hour_btn = hour_r;
    min_btn = min_r;
    if (buttons.set_hour) begin
      hour_btn = (hour_r == sscd_pkg::HOURS_LAST) ? 5'd0 : hour_r + 5'd1;
    end else if (buttons.set_minute) begin
      min_btn = (min_r == sscd_pkg::MINUTES_LAST) ? 6'd0 : min_r + 6'd1;
    end

    slot_nxt = slot_r;
    sec_nxt = sec_r;
    min_nxt = min_r;
    hour_nxt = hour_r;
    if (advance) begin
      if (tick) begin
        slot_nxt = 16'd0;
        hour_nxt = hour_btn;
        min_nxt = min_btn;
        if (sec_r == sscd_pkg::SECONDS_LAST) begin
          sec_nxt = 6'd0;
          if (min_btn == sscd_pkg::MINUTES_LAST) begin
            min_nxt = 6'd0;
            hour_nxt = (hour_btn == sscd_pkg::HOURS_LAST) ? 5'd0 : hour_btn + 5'd1;
          end else begin
            min_nxt = min_btn + 6'd1;
          end
        end else begin
          sec_nxt = sec_r + 6'd1;
        end
      end else begin
        slot_nxt = slot_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 16'd0;
      sec_r <= 6'd0;
      min_r <= 6'd0;
      hour_r <= sscd_pkg::HOURS_RESET;
    end else begin
      slot_r <= slot_nxt;
      sec_r <= sec_nxt;
      min_r <= min_nxt;
      hour_r <= hour_nxt;
    end
  end

  assign now.hours = hour_r;
  assign now.minutes = min_r;

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hour_r <= sscd_pkg::HOURS_LAST) && (min_r <= sscd_pkg::MINUTES_LAST) &&
    (sec_r <= sscd_pkg::SECONDS_LAST))
    else $error("clock count out of range");

  a_second_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && tick && sec_r == sscd_pkg::SECONDS_LAST) |=> (sec_r == 6'd0))
    else $error("seconds did not wrap");

endmodule

// File: hdl/sscd_display.sv
// scan position counter and segment pattern decode
`timescale 1ns / 1ps

module sscd_display (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  logic                            twelve_hour,
  input  sscd_pkg::clock_value_t          now,
  output logic [6:0]                      segments,
  output logic [sscd_pkg::NUM_DIGITS-1:0] digit_select
);

  logic [sscd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [4:0] shown_h;
  logic [4:0] h_mod12;
  logic       pm;

  assign pm = (now.hours >= sscd_pkg::HOURS_NOON);
  assign h_mod12 = pm ? now.hours - sscd_pkg::HOURS_NOON : now.hours;

  always_comb begin
    if (twelve_hour) begin
      shown_h = (h_mod12 == 5'd0) ? sscd_pkg::HOURS_NOON : h_mod12;
    end else begin
      shown_h = now.hours;
    end
  end

  always_comb begin
    unique case (pos_r)
      sscd_pkg::POS_HOUR_TENS: begin
        segments = sscd_pkg::seg_digit(sscd_pkg::dec_tens({1'b0, shown_h}));
        digit_select = 5'b10000;
      end
      sscd_pkg::POS_HOUR_UNITS: begin
        segments = sscd_pkg::seg_digit(sscd_pkg::dec_units({1'b0, shown_h}));
        digit_select = 5'b01000;
      end
      sscd_pkg::POS_MIN_TENS: begin
        segments = sscd_pkg::seg_digit(sscd_pkg::dec_tens(now.minutes));
        digit_select = 5'b00100;
      end
      sscd_pkg::POS_MIN_UNITS: begin
        segments = sscd_pkg::seg_digit(sscd_pkg::dec_units(now.minutes));
        digit_select = 5'b00010;
      end
      sscd_pkg::POS_INDICATOR: begin
        if (!twelve_hour) segments = sscd_pkg::SEG_UNDERSCORE;
        else segments = pm ? sscd_pkg::SEG_P : sscd_pkg::SEG_A;
        digit_select = 5'b00001;
      end
      default: begin
        segments = sscd_pkg::SEG_BLANK;
        digit_select = 5'b10000;
      end
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    if (advance) begin
      pos_nxt = (pos_r == sscd_pkg::POS_INDICATOR) ? sscd_pkg::POS_HOUR_TENS
                                                   : pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= sscd_pkg::POS_HOUR_TENS;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= sscd_pkg::POS_INDICATOR)
    else $error("scan position out of range");

endmodule

// File: hdl/seven_segment_clock_display.sv
// top level of the multiplexed seven-segment time-of-day clock
`timescale 1ns / 1ps

// Each input word is one display scan slot carrying the hour and minute button
// levels and the 12/24-hour mode. The block answers every slot with one output
// word: the segment pattern and one-hot strobe of the position being scanned
// (hour tens, hour units, minute tens, minute units, then the AM/PM or
// underscore indicator), plus the hour and minute counts as they stood before
// that slot. A slot counter makes a second every cfg_slots_per_second slots
// (zero behaves as one); buttons are sampled on that second, hour first. After
// reset the time is 12:00:00 and the register holds 1155. The block takes one
// word per clock while the output does not stall; each word sits in the input
// register, then makes a single pass through the counters and the digit decode
// into the output register. A stalled output holds the input register, so
// in_ready drops only while both registers are full and out_ready is low. The
// register port is always ready; write it only while no word is in flight.

module seven_segment_clock_display (
  input  logic                            clk,
  input  logic                            rst_n,
  // scan slot words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_set_hour,
  input  logic                            in_set_minute,
  input  logic                            in_twelve_hour,
  // display words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [6:0]                      out_segments,
  output logic [sscd_pkg::NUM_DIGITS-1:0] out_digit_select,
  output logic [4:0]                      out_hours_now,
  output logic [5:0]                      out_minutes_now,
  // register write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [15:0]                     cfg_slots_per_second
);

  logic [15:0] spr_r;

  // input register
  logic in_valid_r;
  sscd_pkg::buttons_t btn_r;
  logic twelve_r;

  // output register
  logic out_valid_r;
  logic [6:0] seg_r;
  logic [sscd_pkg::NUM_DIGITS-1:0] sel_r;
  logic [4:0] hours_r;
  logic [5:0] minutes_r;

  logic advance;
  sscd_pkg::clock_value_t now;
  logic [6:0] seg_c;
  logic [sscd_pkg::NUM_DIGITS-1:0] sel_c;

  // the stage moves when a word is held and the output slot is free or leaving
  assign advance = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r <= sscd_pkg::SLOTS_PER_SECOND_RESET;
    end else if (cfg_valid) begin
      spr_r <= cfg_slots_per_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      btn_r.set_hour <= in_set_hour;
      btn_r.set_minute <= in_set_minute;
      twelve_r <= in_twelve_hour;
    end
  end

  sscd_timekeeper u_timekeeper (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .buttons          (btn_r),
    .slots_per_second (spr_r),
    .now              (now)
  );

  sscd_display u_display (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .twelve_hour  (twelve_r),
    .now          (now),
    .segments     (seg_c),
    .digit_select (sel_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // counts are captured before this slot's update lands
  always_ff @(posedge clk) begin
    if (advance) begin
      seg_r <= seg_c;
      sel_r <= sel_c;
      hours_r <= now.hours;
      minutes_r <= now.minutes;
    end
  end

  assign out_valid = out_valid_r;
  assign out_segments = seg_r;
  assign out_digit_select = sel_r;
  assign out_hours_now = hours_r;
  assign out_minutes_now = minutes_r;

  a_strobe_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(sel_r))
    else $error("digit strobe not one-hot");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ready) |-> (!in_ready && !advance))
    else $error("word taken while both registers are full");

endmodule
